@@ sv/ppi_pkg.sv @@
package ppi_pkg;

  localparam int MAX_SAMPLES = 1024;
  localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
  localparam int IDX_W       = $clog2(MAX_SAMPLES);
  localparam int BASE_W      = 10;
  localparam int SAMPLE_W    = 32;
  localparam int HEIGHT_W    = 19;

  localparam int SUM_W  = ((BASE_W > IDX_W) ? BASE_W : IDX_W) + 1;
  localparam int HCALC_W = SUM_W + 8 + 2;

  localparam int NUM_W  = SAMPLE_W + 1 + 7;
  localparam int DEN_W  = SAMPLE_W + 3;
  localparam int QBITS  = 10;
  localparam int DVS_W  = DEN_W + QBITS - 1;
  localparam int STEP_W = $clog2(QBITS);
  localparam int SHIFT_W = 9;

  localparam logic [BASE_W-1:0]   BASE_RESET = BASE_W'(80);
  localparam logic [HEIGHT_W-1:0] HEIGHT_MAX = '1;
  localparam logic [QBITS-2:0]    SHIFT_LIM  = (QBITS-1)'(128);

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last_sample;
  } in_item_t;

  typedef struct packed {
    logic [HEIGHT_W-1:0] peak_height;
    logic                short_profile;
  } out_item_t;

  typedef struct packed {
    logic accept;
    logic prep;
    logic abs_load;
    logic div_step;
    logic emit;
  } ppi_cmd_t;

  typedef struct packed {
    logic interior;
  } ppi_status_t;

endpackage

@@ sv/profile_peak_interpolator_top.sv @@
// Profile peak interpolator.
// Input: a profile is fed one sample per transfer on in_data; a transfer
// happens at a clock edge with start high and busy low. in_data.last_sample
// marks the final sample of a profile. Samples past the maximum profile
// length are dropped, but a last flag on them still closes the profile.
// Non-last samples never raise busy, so a profile streams at one sample
// per clock. The last sample raises busy while the end-of-profile work runs:
// states PREP and EMIT when the peak sits at an edge or the profile is short,
// and PREP, ABS, DIV and EMIT when the parabolic shift is needed (a 10-step
// restoring divider, one quotient bit per cycle). out_valid pulses for one
// cycle with out_data in the first cycle after busy falls; start may be
// taken in that same cycle.
// The receiver cannot stall; each result is presented exactly once.
// Config: cfg_we with cfg_wdata writes the base height; write it only
// while no profile is in flight. Reset (rst_n low, synchronous) clears the
// profile state, sets the base height to 80 km and drops out_valid.
module profile_peak_interpolator_top (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  ppi_pkg::in_item_t          in_data,
  output logic                       out_valid,
  output ppi_pkg::out_item_t         out_data,
  input  logic                       cfg_we,
  input  logic [ppi_pkg::BASE_W-1:0] cfg_wdata
);
  import ppi_pkg::*;

  ppi_cmd_t    cmd;
  ppi_status_t status;

  ppi_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .last_sample (in_data.last_sample),
    .status      (status),
    .cmd         (cmd),
    .busy        (busy)
  );

  ppi_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

@@ sv/ppi_ctrl.sv @@
module ppi_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 last_sample,
  input  ppi_pkg::ppi_status_t status,
  output ppi_pkg::ppi_cmd_t    cmd,
  output logic                 busy
);
  import ppi_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PREP = 3'd1;
  localparam logic [2:0] ST_ABS  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;

  always_comb begin
    state_nxt    = state_r;
    step_nxt     = step_r;
    cmd          = '0;
    unique case (state_r)
      ST_IDLE: begin
        cmd.accept = start;
        if (start && last_sample) begin
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd.prep = 1'b1;
        state_nxt = status.interior ? ST_ABS : ST_EMIT;
      end
      ST_ABS: begin
        cmd.abs_load = 1'b1;
        step_nxt     = STEP_W'(QBITS - 1);
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        step_nxt     = step_r - STEP_W'(1);
        if (step_r == '0) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        cmd.emit  = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy = (state_r != ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

endmodule

@@ sv/ppi_datapath.sv @@
module ppi_datapath (
  input  logic                         clk,
  input  logic                         rst_n,
  input  ppi_pkg::in_item_t            in_data,
  input  logic                         cfg_we,
  input  logic [ppi_pkg::BASE_W-1:0]   cfg_wdata,
  input  ppi_pkg::ppi_cmd_t            cmd,
  output ppi_pkg::ppi_status_t         status,
  output logic                         out_valid,
  output ppi_pkg::out_item_t           out_data
);
  import ppi_pkg::*;

  logic [BASE_W-1:0]          base_r;
  logic [CNT_W-1:0]           count_r, count_nxt;
  logic [IDX_W-1:0]           best_idx_r, best_idx_nxt;
  logic signed [SAMPLE_W-1:0] best_r, best_nxt;
  logic signed [SAMPLE_W-1:0] before_r, before_nxt;
  logic signed [SAMPLE_W-1:0] after_r, after_nxt;
  logic signed [SAMPLE_W-1:0] prev_r, prev_nxt;
  logic                       awaiting_r, awaiting_nxt;

  logic signed [NUM_W-1:0] num_r;
  logic signed [DEN_W-1:0] den_r;
  logic                    neg_r, dzero_r;
  logic [NUM_W-1:0]        rem_r;
  logic [DVS_W-1:0]        dvs_r;
  logic [QBITS-1:0]        quo_r;

  logic                    out_valid_r;
  out_item_t               out_data_r, out_data_nxt;

  logic                    interior, short_prof;
  logic [DVS_W-1:0]        rem_ext;
  logic                    ge;
  logic [SHIFT_W-1:0]      mag;
  logic signed [SHIFT_W-1:0] shift;
  logic [SUM_W-1:0]        hsum;
  logic signed [HCALC_W-1:0] hcalc;

  always_comb begin
    count_nxt    = count_r;
    best_idx_nxt = best_idx_r;
    best_nxt     = best_r;
    before_nxt   = before_r;
    after_nxt    = after_r;
    prev_nxt     = prev_r;
    awaiting_nxt = awaiting_r;
    if (cmd.accept && (count_r < CNT_W'(MAX_SAMPLES))) begin
      if (count_r == '0) begin
        best_nxt     = in_data.sample;
        best_idx_nxt = '0;
        before_nxt   = '0;
        awaiting_nxt = 1'b1;
      end else if (in_data.sample > best_r) begin
        before_nxt   = prev_r;
        best_nxt     = in_data.sample;
        best_idx_nxt = count_r[IDX_W-1:0];
        awaiting_nxt = 1'b1;
      end else if (awaiting_r) begin
        after_nxt    = in_data.sample;
        awaiting_nxt = 1'b0;
      end
      prev_nxt  = in_data.sample;
      count_nxt = count_r + CNT_W'(1);
    end
    if (cmd.emit) begin
      count_nxt    = '0;
      best_idx_nxt = '0;
      best_nxt     = '0;
      before_nxt   = '0;
      after_nxt    = '0;
      prev_nxt     = '0;
      awaiting_nxt = 1'b0;
    end
  end

  assign interior   = (best_idx_r != '0) &&
                      ((CNT_W'(best_idx_r) + CNT_W'(1)) < count_r);
  assign short_prof = (count_r < CNT_W'(3));
  assign status.interior = interior;

  // restoring division step, quotient MSB flags saturation
  assign rem_ext = DVS_W'(rem_r);
  assign ge      = (rem_ext >= dvs_r);

  always_comb begin
    if (quo_r[QBITS-1] || (quo_r[QBITS-2:0] > SHIFT_LIM)) begin
      mag = SHIFT_W'(SHIFT_LIM);
    end else begin
      mag = SHIFT_W'(quo_r[QBITS-2:0]);
    end
    if (!interior || dzero_r) begin
      shift = '0;
    end else if (neg_r) begin
      shift = -$signed(mag);
    end else begin
      shift = $signed(mag);
    end
    hsum  = SUM_W'(base_r) + SUM_W'(best_idx_r);
    hcalc = $signed({2'b00, hsum, 8'h00}) + HCALC_W'(shift);
    out_data_nxt = out_data_r;
    if (short_prof) begin
      out_data_nxt.peak_height   = '0;
      out_data_nxt.short_profile = 1'b1;
    end else begin
      out_data_nxt.short_profile = 1'b0;
      if (hcalc < 0) begin
        out_data_nxt.peak_height = '0;
      end else if (hcalc > $signed(HCALC_W'(HEIGHT_MAX))) begin
        out_data_nxt.peak_height = HEIGHT_MAX;
      end else begin
        out_data_nxt.peak_height = hcalc[HEIGHT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r      <= BASE_RESET;
      count_r     <= '0;
      best_idx_r  <= '0;
      best_r      <= '0;
      before_r    <= '0;
      after_r     <= '0;
      prev_r      <= '0;
      awaiting_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        base_r <= cfg_wdata;
      end
      count_r     <= count_nxt;
      best_idx_r  <= best_idx_nxt;
      best_r      <= best_nxt;
      before_r    <= before_nxt;
      after_r     <= after_nxt;
      prev_r      <= prev_nxt;
      awaiting_r  <= awaiting_nxt;
      out_valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      num_r <= ($signed((NUM_W-7)'(before_r)) - $signed((NUM_W-7)'(after_r))) <<< 7;
      den_r <= DEN_W'(before_r) - (DEN_W'(best_r) <<< 1) + DEN_W'(after_r);
    end
    if (cmd.abs_load) begin
      neg_r   <= num_r[NUM_W-1] ^ den_r[DEN_W-1];
      dzero_r <= (den_r == '0);
      rem_r   <= num_r[NUM_W-1] ? NUM_W'(-num_r) : NUM_W'(num_r);
      dvs_r   <= {(den_r[DEN_W-1] ? DEN_W'(-den_r) : DEN_W'(den_r)), (QBITS-1)'(0)};
      quo_r   <= '0;
    end
    if (cmd.div_step) begin
      if (ge) begin
        rem_r <= NUM_W'(rem_ext - dvs_r);
      end
      quo_r <= {quo_r[QBITS-2:0], ge};
      dvs_r <= dvs_r >> 1;
    end
    if (cmd.emit) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ bench/profile_peak_interpolator_top_tb.sv @@
`timescale 1ns / 100ps

module profile_peak_interpolator_top_tb;
  import ppi_pkg::*;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  localparam sample_t S_MIN = 32'sh8000_0000;
  localparam sample_t S_MAX = 32'sh7FFF_FFFF;
  localparam int SETTLE_CYCLES = 20;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_ITEMS = 50;

  class peak_height_scoreboard;
    logic [BASE_W-1:0] base_km;
    int unsigned n_taken;
    int unsigned peak_idx;
    longint peak_val;
    longint left_val;
    longint right_val;
    longint prev_val;
    bit want_right;
    out_item_t expected_peaks[$];
    int unsigned mismatches;

    function new();
      base_km = BASE_RESET;
      mismatches = 0;
      restart();
    endfunction

    function void restart();
      n_taken = 0;
      peak_idx = 0;
      peak_val = 0;
      left_val = 0;
      right_val = 0;
      prev_val = 0;
      want_right = 0;
    endfunction

    function void load_base(logic [BASE_W-1:0] km);
      base_km = km;
    endfunction

    function int pending();
      return expected_peaks.size();
    endfunction

    function void note_sample(in_item_t it);
      longint s;
      longint den;
      longint q;
      longint h;
      out_item_t want;
      s = $signed(it.sample);
      if (n_taken < MAX_SAMPLES) begin
        if (n_taken == 0) begin
          peak_val = s;
          peak_idx = 0;
          left_val = 0;
          want_right = 1;
        end else if (s > peak_val) begin
          left_val = prev_val;
          peak_val = s;
          peak_idx = n_taken;
          want_right = 1;
        end else if (want_right) begin
          right_val = s;
          want_right = 0;
        end
        prev_val = s;
        n_taken++;
      end
      if (!it.last_sample) return;
      if (n_taken < 3) begin
        want.peak_height = '0;
        want.short_profile = 1'b1;
      end else begin
        h = (longint'(base_km) + longint'(peak_idx)) * 256;
        if (peak_idx != 0 && peak_idx + 1 < n_taken) begin
          den = left_val - 2 * peak_val + right_val;
          if (den != 0) begin
            q = (128 * (left_val - right_val)) / den;
            if (q > 128) q = 128;
            if (q < -128) q = -128;
            h += q;
          end
        end
        if (h < 0) h = 0;
        if (h > longint'(HEIGHT_MAX)) h = longint'(HEIGHT_MAX);
        want.peak_height = h[HEIGHT_W-1:0];
        want.short_profile = 1'b0;
      end
      expected_peaks.push_back(want);
      restart();
    endfunction

    function void check_peak(out_item_t got);
      out_item_t want;
      if (expected_peaks.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result, height %0d short %0b", $time,
                   got.peak_height, got.short_profile);
        return;
      end
      want = expected_peaks.pop_front();
      if (got.peak_height !== want.peak_height || got.short_profile !== want.short_profile)
      begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: mismatch, expected height %0d short %0b, got height %0d short %0b",
                   $time, want.peak_height, want.short_profile,
                   got.peak_height, got.short_profile);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_item_t in_data = '0;
  logic out_valid;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [BASE_W-1:0] cfg_wdata = '0;

  peak_height_scoreboard sb = new();
  int unsigned idle_cycles = 0;
  int unsigned items_sent = 0;

  profile_peak_interpolator_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) sb.check_peak(out_data);
      if (out_valid || (start && !busy)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("profile_peak_interpolator_top test failed");
        $finish;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_sample(input sample_t s, input logic last, input int gap);
    in_item_t it;
    it.sample = s;
    it.last_sample = last;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_sample(it);
    items_sent++;
  endtask

  task automatic send_profile(input sample_t vals[$]);
    bit tight;
    tight = ($urandom_range(3) == 0);
    foreach (vals[i])
      send_sample(vals[i], i == vals.size() - 1, tight ? 0 : pick_gap());
  endtask

  task automatic write_base(input logic [BASE_W-1:0] km);
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= km;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.load_base(km);
  endtask

  task automatic build_profile(ref sample_t vals[$]);
    int len;
    int r;
    int p;
    longint top;
    longint slope;
    longint v;
    sample_t picks[6];
    picks = '{S_MIN, S_MAX, S_MIN + 1, S_MAX - 1, 0, -1};
    vals.delete();
    r = $urandom_range(99);
    if (r < 8) len = $urandom_range(1, 2);
    else if (r < 90) len = $urandom_range(3, 16);
    else len = $urandom_range(17, 64);
    p = $urandom_range(len - 1);
    top = longint'($urandom_range(0, 1 << 21)) - (1 << 20);
    slope = $urandom_range(1, 4000);
    v = $signed($urandom());
    case ($urandom_range(4))
      0: for (int i = 0; i < len; i++) vals.push_back($urandom());
      1: for (int i = 0; i < len; i++)
        vals.push_back(sample_t'(top - slope * ((i > p) ? i - p : p - i)
                                 + $urandom_range(0, 2 * slope)));
      2: for (int i = 0; i < len; i++) vals.push_back($urandom_range(0, 15) - 8);
      3: for (int i = 0; i < len; i++) vals.push_back(picks[$urandom_range(5)]);
      default: begin
        if ($urandom_range(1)) slope = -slope;
        for (int i = 0; i < len; i++) vals.push_back(sample_t'(v + slope * i));
      end
    endcase
  endtask

  task automatic run_directed();
    sample_t q[$];
    q = '{32'sd7};                        send_profile(q);
    q = '{-32'sd5, 32'sd9};               send_profile(q);
    q = '{32'sd0, 32'sd100, 32'sd50};     send_profile(q);
    q = '{S_MIN, S_MAX, S_MIN};           send_profile(q);
    q = '{S_MAX - 1, S_MAX, S_MIN};       send_profile(q);
    q = '{S_MIN, S_MIN + 1, S_MAX};       send_profile(q);
    q = '{S_MAX, 32'sd0, -32'sd1};        send_profile(q);
    q = '{32'sd5, 32'sd5, 32'sd5};        send_profile(q);
    q = '{32'sd1, 32'sd5, 32'sd5, 32'sd2}; send_profile(q);
  endtask

  task automatic run_overlong();
    sample_t q[$];
    q.delete();
    for (int i = 0; i < 1026; i++) q.push_back($urandom_range(0, 15) - 8);
    q[1023] = 32'sd1000;
    q[1025] = S_MAX;
    send_profile(q);
  endtask

  initial begin
    sample_t prof[$];
    logic [BASE_W-1:0] bases[5];
    int target;
    bases = '{10'd0, 10'd1023, 10'($urandom_range(1, 1022)), 10'd512,
              10'($urandom_range(1, 1022))};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    foreach (bases[k]) begin
      write_base(bases[k]);
      if (k == 1) run_overlong();
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) begin
        build_profile(prof);
        send_profile(prof);
      end
    end
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("profile_peak_interpolator_top test passed");
    end else begin
      $display("profile_peak_interpolator_top test failed");
    end
    $finish;
  end

endmodule
